// ----- src/pvg_pkg.sv -----
// shared constants, path commands and cordic helpers for the polygon/star generator
package pvg_pkg;

  localparam int STORE_DEPTH     = 32;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int MAX_POINTS_DEF  = 16;
  localparam int MATCH_TOL_DEF   = 1;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [1:0] CMD_MOVE  = 2'd0;
  localparam logic [1:0] CMD_LINE  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_EMPTY = 2'd3;

  // arctangent step per cordic iteration, units of 2^-24 turn
  function automatic logic signed [23:0] atan_step(input logic [3:0] i);
    logic signed [23:0] v;
    case (i)
      4'd0:  v = 24'sd2097152;
      4'd1:  v = 24'sd1238021;
      4'd2:  v = 24'sd654136;
      4'd3:  v = 24'sd332050;
      4'd4:  v = 24'sd166669;
      4'd5:  v = 24'sd83416;
      4'd6:  v = 24'sd41718;
      4'd7:  v = 24'sd20860;
      4'd8:  v = 24'sd10430;
      4'd9:  v = 24'sd5215;
      4'd10: v = 24'sd2608;
      4'd11: v = 24'sd1304;
      4'd12: v = 24'sd652;
      4'd13: v = 24'sd326;
      4'd14: v = 24'sd163;
      4'd15: v = 24'sd81;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  // q.30 to q1.15, round half up, clamp
  function automatic logic signed [15:0] q30_to_q15(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [18:0] r;
    t = 34'(v) + 34'sd16384;
    r = 19'(t >>> 15);
    if (r > 19'sd32767) return 16'sh7FFF;
    if (r < -19'sd32768) return 16'sh8000;
    return 16'(r);
  endfunction

endpackage

// ----- src/polygon_star_vertex_generator_unit.sv -----
// polygon/star vertex generator: one request in, a path of move/line/close items or a lone empty item out
// steps: bit-serial phase divider, then per vertex a 16-step cordic, the multiply
//   states and a store state, then a read state and a put state per emitted item
// one request at a time, up to 32 vertices per request
// the next request is taken once the last item sits in the output register
// reset (rst, synchronous): control state idle, output empty; vertex memory not cleared
module polygon_star_vertex_generator_unit
  import pvg_pkg::*;
#(
  parameter int MAX_POINTS      = MAX_POINTS_DEF,
  parameter int MATCH_TOLERANCE = MATCH_TOL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // shape_width[15:0], shape_height[31:16], vertex_count[36:32], inner_radius[52:37]
  input  logic [55:0] s_tdata,
  // req_type[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // path_cmd[1:0], x_coord[19:2], y_coord[37:20]
  output logic [39:0] m_tdata,
  output logic        m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CINIT, S_CORDIC, S_MUL1X, S_MUL2X, S_MUL1Y, S_MUL2Y,
    S_STORE, S_FINISH, S_EMIT_RD, S_EMIT_PUT, S_CLOSE, S_EMPTY
  } state_t;

  state_t state;

  // request registers
  logic        star;
  logic [15:0] w, h, rin;
  logic [5:0]  n, m, k;

  // phase divider and incremental phase
  logic [4:0]  dbit;
  logic [6:0]  rem;
  logic [23:0] q0, ph;
  logic [6:0]  rr;

  // cordic
  logic signed [31:0] cx, cy;
  logic signed [23:0] cz;
  logic [3:0]         it;
  logic signed [15:0] cos_q;

  // mapping multiplier
  logic signed [33:0] prod1;
  logic signed [51:0] prod2;
  logic [17:0]        xnew;

  // vertex bookkeeping
  logic [35:0] lastv, firstv;
  logic [5:0]  cnt, idx;
  logic        close;

  // vertex memory, x in 17..0, y in 35..18
  logic [35:0] vmem [STORE_DEPTH];
  logic [35:0] mem_q;
  logic        mem_we;
  logic [STORE_AW-1:0] raddr;

  function automatic logic near(input logic [35:0] a, input logic [35:0] b);
    logic signed [18:0] dx, dy;
    dx = 19'($signed(a[17:0])) - 19'($signed(b[17:0]));
    dy = 19'($signed(a[35:18])) - 19'($signed(b[35:18]));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx <= 19'(MATCH_TOLERANCE)) && (dy <= 19'(MATCH_TOLERANCE));
  endfunction

  // input field decode and count clamp
  logic [5:0] n_in;
  logic [5:0] n_clamp;
  always_comb begin
    n_in = {1'b0, s_tdata[36:32]};
    n_clamp = n_in;
    if (n_clamp > 6'(MAX_POINTS)) n_clamp = 6'(MAX_POINTS);
    if (s_tuser[0] && n_clamp > 6'(STORE_DEPTH / 2)) n_clamp = 6'(STORE_DEPTH / 2);
    if (n_clamp > 6'(STORE_DEPTH)) n_clamp = 6'(STORE_DEPTH);
  end

  // divider step: dividend is a single one bit at 24 (polygon) or 23 (star)
  logic       div_bit;
  logic [6:0] div_rs;
  logic       div_ge;
  always_comb begin
    div_bit = star ? (dbit == 5'd23) : (dbit == 5'd24);
    div_rs  = {rem[5:0], div_bit};
    div_ge  = div_rs >= {1'b0, n};
  end

  // cordic rotation to full circle
  logic signed [32:0] s_full, c_full;
  always_comb begin
    case (ph[23:22])
      2'd0: begin c_full = 33'(cx);  s_full = 33'(cy);  end
      2'd1: begin c_full = -33'(cy); s_full = 33'(cx);  end
      2'd2: begin c_full = -33'(cx); s_full = -33'(cy); end
      default: begin c_full = 33'(cy); s_full = -33'(cx); end
    endcase
  end

  // radius: outer for polygon and even star points
  logic [15:0] rad;
  assign rad = (star && k[0]) ? rin : 16'd32768;

  // mapped coordinate: floor(((q30 + 2^30)*dim + 2^30) / 2^31)
  logic signed [51:0] mapped;
  logic [17:0]        mcoord;
  assign mapped = prod2 + 52'sd1073741824;
  assign mcoord = mapped[48:31];

  logic [35:0] newv;
  logic        keep;
  assign newv = {mcoord, xnew};
  assign keep = (cnt == 6'd0) || !near(lastv, newv);
  assign mem_we = (state == S_STORE) && keep && (cnt < 6'(STORE_DEPTH));

  // end of vertex list: drop a repeated first vertex
  logic [5:0] cnt_fin;
  always_comb begin
    cnt_fin = cnt;
    if (m >= 6'd2 && cnt >= 6'd1 && (cnt == 6'd1 || near(firstv, lastv)))
      cnt_fin = cnt - 6'd1;
  end

  logic out_free;
  logic load_out;
  assign out_free = !m_tvalid || m_tready;
  // output register takes a new item in the emit, close and empty states
  assign load_out = out_free &&
                    (state == S_EMIT_PUT || state == S_CLOSE || state == S_EMPTY);
  assign s_tready = (state == S_IDLE);
  assign raddr    = idx[STORE_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) vmem[cnt[STORE_AW-1:0]] <= newv;
    mem_q <= vmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      idx      <= '0;
      close    <= 1'b0;
    end else begin
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            star <= s_tuser[0];
            w    <= s_tdata[15:0];
            h    <= s_tdata[31:16];
            rin  <= s_tdata[52:37];
            n    <= n_clamp;
            m    <= (n_clamp == 6'd0) ? 6'd0 : (s_tuser[0] ? 6'(n_clamp << 1) : n_clamp);
            k    <= '0;
            cnt  <= '0;
            rem  <= '0;
            q0   <= '0;
            dbit <= 5'd24;
            state <= (n_clamp == 6'd0) ? S_FINISH : S_DIV;
          end
        end
        S_DIV: begin
          rem <= div_ge ? (div_rs - {1'b0, n}) : div_rs;
          q0  <= {q0[22:0], div_ge};
          if (dbit == 5'd0) begin
            ph    <= '0;
            rr    <= {2'b0, n[5:1]};
            state <= S_CINIT;
          end
          dbit <= dbit - 5'd1;
        end
        S_CINIT: begin
          cx    <= CORDIC_GAIN;
          cy    <= '0;
          cz    <= {2'b00, ph[21:0]};
          it    <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - (cy >>> it);
            cy <= cy + (cx >>> it);
            cz <= cz - atan_step(it);
          end else begin
            cx <= cx + (cy >>> it);
            cy <= cy - (cx >>> it);
            cz <= cz + atan_step(it);
          end
          it <= it + 4'd1;
          if (it == 4'd15) state <= S_MUL1X;
        end
        S_MUL1X: begin
          cos_q <= q30_to_q15(c_full);
          prod1 <= 34'(q30_to_q15(s_full)) * $signed({1'b0, rad});
          state <= S_MUL2X;
        end
        S_MUL2X: begin
          prod2 <= (35'(prod1) + 35'sd1073741824) * $signed({1'b0, w});
          state <= S_MUL1Y;
        end
        S_MUL1Y: begin
          xnew  <= mcoord;
          prod1 <= (-34'(cos_q)) * $signed({1'b0, rad});
          state <= S_MUL2Y;
        end
        S_MUL2Y: begin
          prod2 <= (35'(prod1) + 35'sd1073741824) * $signed({1'b0, h});
          state <= S_STORE;
        end
        S_STORE: begin
          if (mem_we) begin
            cnt   <= cnt + 6'd1;
            lastv <= newv;
            if (cnt == 6'd0) firstv <= newv;
          end
          // next phase: q += q0, r += r0 with one correction
          if (rr + 7'(rem) >= {1'b0, n}) begin
            rr <= rr + 7'(rem) - {1'b0, n};
            ph <= ph + q0 + 24'd1;
          end else begin
            rr <= rr + 7'(rem);
            ph <= ph + q0;
          end
          k <= k + 6'd1;
          state <= (k + 6'd1 == m) ? S_FINISH : S_CINIT;
        end
        S_FINISH: begin
          cnt   <= cnt_fin;
          close <= cnt_fin >= 6'd3;
          idx   <= '0;
          state <= (m < 6'd2 || cnt_fin < 6'd2) ? S_EMPTY : S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_PUT;
        end
        S_EMIT_PUT: begin
          if (out_free) begin
            m_tdata  <= {2'b00, mem_q[35:18], mem_q[17:0],
                         (idx == 6'd0) ? CMD_MOVE : CMD_LINE};
            m_tlast  <= !close && (idx + 6'd1 == cnt);
            idx      <= idx + 6'd1;
            if (idx + 6'd1 == cnt) state <= close ? S_CLOSE : S_IDLE;
            else                   state <= S_EMIT_RD;
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            m_tdata  <= {38'd0, CMD_CLOSE};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            m_tdata  <= {38'd0, CMD_EMPTY};
            m_tlast  <= 1'b1;
            cnt      <= '0;
            close    <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/polygon_star_vertex_generator_unit_tb.sv -----
// testbench for the polygon/star vertex generator: directed table, random requests, path check
`timescale 1ns / 1ps

module polygon_star_vertex_generator_unit_tb
  import pvg_pkg::*;
();

  localparam int RANDOM_REQS  = 290;
  localparam int STALL_LIMIT  = 20000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 100;

  localparam logic [0:0] KIND_POLYGON = 1'b0;
  localparam logic [0:0] KIND_STAR    = 1'b1;

  // one path item on the output
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               last;
  } path_item_t;

  // one row of the directed table; empty marks a row whose answer is a lone empty path
  typedef struct {
    logic [0:0]  kind;
    logic [15:0] w;
    logic [15:0] h;
    logic [4:0]  n;
    logic [15:0] rin;
    bit          empty;
  } shape_row_t;

  localparam longint ARC_STEP [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                        41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                        163, 81};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  path_item_t  path_fifo[$];
  int          error_count = 0;
  int          reqs_sent = 0;
  int          idle_cycles = 0;
  bit          no_idling = 0;
  bit          hold_done = 0;
  int          hold_left = 0;

  polygon_star_vertex_generator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  // append one expected item at the tail of the queue
  task automatic queue_item(input path_item_t item);
    path_fifo.insert(path_fifo.size(), item);
  endtask

  // rotate within one quadrant by cordic, then place in the quadrant; q1.15 out
  function automatic void trig_of_phase(input logic [23:0] phase, output longint sn,
                                        output longint cs);
    longint cx, cy, z, dx, dy, s30, c30;
    cx = 652032874;
    cy = 0;
    z = longint'(phase[21:0]);
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= ARC_STEP[i];
      end else begin
        cx += dx; cy -= dy; z += ARC_STEP[i];
      end
    end
    case (phase[23:22])
      2'd0: begin c30 = cx;  s30 = cy;  end
      2'd1: begin c30 = -cy; s30 = cx;  end
      2'd2: begin c30 = -cx; s30 = -cy; end
      default: begin c30 = cy; s30 = -cx; end
    endcase
    sn = (s30 + 16384) >>> 15;
    cs = (c30 + 16384) >>> 15;
    if (sn > 32767) sn = 32767;
    if (sn < -32768) sn = -32768;
    if (cs > 32767) cs = 32767;
    if (cs < -32768) cs = -32768;
  endfunction

  // unit-box q.30 coordinate to box units
  function automatic logic signed [17:0] box_coord(input longint q30, input longint dim);
    longint v;
    v = (q30 + (64'sd1 <<< 30)) * dim + (64'sd1 <<< 30) + (64'sd1 <<< 48);
    return 18'((v >>> 31) - (64'sd1 <<< 17));
  endfunction

  function automatic bit close_by(input logic signed [17:0] ax, ay, bx, by);
    longint ddx, ddy;
    ddx = longint'(ax) - longint'(bx);
    ddy = longint'(ay) - longint'(by);
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    return ddx <= MATCH_TOL_DEF && ddy <= MATCH_TOL_DEF;
  endfunction

  // build the outline of one request and queue its path items
  task automatic predict_outline(input logic [0:0] kind, input logic [15:0] w, h,
                                 input logic [4:0] n_in, input logic [15:0] rin);
    logic signed [17:0] vx [32];
    logic signed [17:0] vy [32];
    logic signed [17:0] px, py;
    logic [23:0] phase;
    longint num, sn, cs, rad;
    int n, m, cnt;
    bit closed;
    path_item_t it;
    n = n_in;
    cnt = 0;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    if (kind == KIND_STAR && n > STORE_DEPTH / 2) n = STORE_DEPTH / 2;
    m = (n == 0) ? 0 : ((kind == KIND_STAR) ? 2 * n : n);
    for (int k = 0; k < m; k++) begin
      num = (kind == KIND_STAR) ? (longint'(k) <<< 23) : (longint'(k) <<< 24);
      phase = 24'((num + n / 2) / n);
      rad = (kind == KIND_STAR && k % 2 == 1) ? longint'(rin) : 32768;
      trig_of_phase(phase, sn, cs);
      px = box_coord(sn * rad, w);
      py = box_coord(-cs * rad, h);
      if (cnt > 0 && close_by(vx[cnt-1], vy[cnt-1], px, py)) continue;
      if (cnt < STORE_DEPTH) begin
        vx[cnt] = px;
        vy[cnt] = py;
        cnt++;
      end
    end
    // a last vertex back on the first is dropped; three or more vertices close the path
    closed = 1;
    if (m >= 2 && cnt >= 1)
      if (cnt == 1 || close_by(vx[0], vy[0], vx[cnt-1], vy[cnt-1])) cnt--;
    if (cnt < 3) closed = 0;
    if (m < 2 || cnt < 2) begin
      queue_item('{CMD_EMPTY, 18'sd0, 18'sd0, 1'b1});
      return;
    end
    for (int e = 0; e < cnt; e++) begin
      it.cmd = (e == 0) ? CMD_MOVE : CMD_LINE;
      it.x = vx[e];
      it.y = vy[e];
      it.last = !closed && (e + 1 == cnt);
      queue_item(it);
    end
    if (closed) queue_item('{CMD_CLOSE, 18'sd0, 18'sd0, 1'b1});
  endtask

  // offer one request, optionally after an idle gap; predict once it is taken
  task automatic offer_request(input shape_row_t r);
    if (!no_idling && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {3'b000, r.rin, r.n, r.h, r.w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reqs_sent++;
    if (r.empty) queue_item('{CMD_EMPTY, 18'sd0, 18'sd0, 1'b1});
    else predict_outline(r.kind, r.w, r.h, r.n, r.rin);
  endtask

  // directed rows: empty paths, count clamps, extreme boxes and radii
  shape_row_t directed_rows [] = '{
    '{KIND_POLYGON, 16'd1000,  16'd1000,  5'd0,  16'd0,     1'b1},
    '{KIND_STAR,    16'd1000,  16'd1000,  5'd0,  16'd16384, 1'b1},
    '{KIND_POLYGON, 16'd65535, 16'd65535, 5'd1,  16'd0,     1'b1},
    '{KIND_POLYGON, 16'd0,     16'd0,     5'd5,  16'd0,     1'b1},
    '{KIND_STAR,    16'd0,     16'd0,     5'd7,  16'd65535, 1'b1},
    '{KIND_POLYGON, 16'd400,   16'd300,   5'd2,  16'd0,     1'b0},
    '{KIND_POLYGON, 16'd400,   16'd300,   5'd3,  16'd0,     1'b0},
    '{KIND_POLYGON, 16'd65535, 16'd65535, 5'd4,  16'd0,     1'b0},
    '{KIND_POLYGON, 16'd65535, 16'd65535, 5'd16, 16'd0,     1'b0},
    '{KIND_POLYGON, 16'd5000,  16'd7000,  5'd31, 16'd65535, 1'b0},
    '{KIND_POLYGON, 16'd65535, 16'd0,     5'd6,  16'd0,     1'b0},
    '{KIND_POLYGON, 16'd2,     16'd2,     5'd8,  16'd0,     1'b0},
    '{KIND_STAR,    16'd1000,  16'd1000,  5'd5,  16'd16384, 1'b0},
    '{KIND_STAR,    16'd65535, 16'd65535, 5'd16, 16'd65535, 1'b0},
    '{KIND_STAR,    16'd800,   16'd600,   5'd31, 16'd0,     1'b0},
    '{KIND_STAR,    16'd800,   16'd600,   5'd1,  16'd32768, 1'b0},
    '{KIND_STAR,    16'd800,   16'd600,   5'd2,  16'd0,     1'b0},
    '{KIND_STAR,    16'd900,   16'd900,   5'd6,  16'd32768, 1'b0},
    '{KIND_STAR,    16'd3,     16'd3,     5'd9,  16'd20000, 1'b0},
    '{KIND_STAR,    16'd0,     16'd65535, 5'd4,  16'd65535, 1'b0}
  };

  // sender
  initial begin
    shape_row_t r;
    int pick;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) offer_request(directed_rows[i]);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      no_idling = (i >= 150 && i < 210);   // stretch with no gaps on either side
      r.kind = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      r.w = (pick == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom_range(0, 65535));
      r.h = (pick == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom_range(0, 65535));
      r.n = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(17, 31));
      r.rin = 16'($urandom_range(0, 65535));
      r.empty = 1'b0;
      offer_request(r);
    end
    no_idling = 0;
    s_tvalid <= 1'b0;
    while (path_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && reqs_sent >= 60) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idling || ($urandom_range(0, 99) >= 24);
    end
  end

  // path checker, field by field against the oldest expected item
  always @(posedge clk) begin
    path_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (path_fifo.size() == 0) begin
        $display("unexpected item cmd %0d (t=%0t)", m_tdata[1:0], $realtime);
        error_count++;
      end else begin
        want = path_fifo.pop_front();
        if (m_tdata[1:0] !== want.cmd) report_mismatch("path_cmd", m_tdata[1:0], want.cmd);
        if ($signed(m_tdata[19:2]) !== want.x)
          report_mismatch("x_coord", $signed(m_tdata[19:2]), want.x);
        if ($signed(m_tdata[37:20]) !== want.y)
          report_mismatch("y_coord", $signed(m_tdata[37:20]), want.y);
        if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
